@@ hw/rtl/dmac_pkg.sv @@
// dmac_pkg: shared types and constants of the moving average crossover block
// used by every module under hw/rtl; no dependencies
package dmac_pkg;

   localparam logic [1:0] REG_SHORT_LEN  = 2'd0;
   localparam logic [1:0] REG_LONG_LEN   = 2'd1;
   localparam logic [1:0] REG_WINDOW_LEN = 2'd2;
   localparam logic [1:0] REG_INST_COUNT = 2'd3;

   localparam logic [5:0] SHORT_LEN_RESET  = 6'd5;
   localparam logic [5:0] LONG_LEN_RESET   = 6'd20;
   localparam logic [6:0] WINDOW_LEN_RESET = 7'd21;
   localparam logic [4:0] INST_COUNT_RESET = 5'd1;

   localparam logic [31:0] PRICE_OFFSET = 32'd300;
   localparam logic [19:0] BUY_CAP      = 20'd100;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic [4:0] instrument_count;
      logic [6:0] window_len;
      logic [5:0] long_len;
      logic [5:0] short_len;
   } cfg_type;

   typedef struct packed {
      logic [19:0] closed_volume;
      logic [19:0] open_volume;
      logic [47:0] position_cost;
      logic [47:0] total_assets;
      logic [30:0] close_price;
      logic [3:0]  instrument;
   } bar_type;

endpackage

@@ hw/rtl/dmac_front.sv @@
// dmac_front: accepts bars, drops those for unknown instruments, feeds the queue
// depends on dmac_pkg
module dmac_front #(
   parameter int MAX_INSTRUMENTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dmac_pkg::bar_type in_bar,
   input  logic [4:0]        inst_count,
   output logic              push,
   output dmac_pkg::bar_type push_bar,
   input  logic              q_full
);
   logic known;
   logic [8:0] inst9;

   assign inst9 = 9'(in_bar.instrument);
   // bars for instruments beyond the count are accepted and discarded
   assign known = (inst9 < 9'(inst_count)) && (inst9 < 9'(MAX_INSTRUMENTS));

   logic stage_valid_ff;
   dmac_pkg::bar_type stage_bar_ff;

   assign in_ready = !stage_valid_ff || !q_full;
   assign push     = stage_valid_ff && !q_full;
   assign push_bar = stage_bar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (in_ready) begin
         stage_valid_ff <= in_valid && known;
      end
      if (in_ready) begin
         stage_bar_ff <= in_bar;
      end
   end
endmodule

@@ hw/rtl/dmac_queue.sv @@
// dmac_queue: two-entry queue of bars between front and back
// depends on dmac_pkg
module dmac_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dmac_pkg::bar_type push_bar,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output dmac_pkg::bar_type head_bar
);
   dmac_pkg::bar_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_bar  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_bar;
   end
endmodule

@@ hw/rtl/dmac_back.sv @@
// dmac_back: per-instrument history, running sums, crossover test and order sizing
// depends on dmac_pkg
module dmac_back #(
   parameter int MAX_INSTRUMENTS = 16,
   parameter int MAX_WINDOW      = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  dmac_pkg::cfg_type cfg,
   input  logic              clear_tracks,
   input  logic              q_not_empty,
   input  dmac_pkg::bar_type q_bar,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_side,
   output logic [3:0]        rsp_inst,
   output logic [31:0]       rsp_price,
   output logic [19:0]       rsp_volume
);
   localparam int IW  = (MAX_INSTRUMENTS > 1) ? $clog2(MAX_INSTRUMENTS) : 1;
   localparam int SLW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FW  = $clog2(MAX_WINDOW + 1);
   localparam int SW  = 31 + SLW;
   localparam int AW  = $clog2(MAX_INSTRUMENTS * MAX_WINDOW);
   localparam int PW  = SW + FW;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDS  = 4'd1;
   localparam logic [3:0] ST_RDL  = 4'd2;
   localparam logic [3:0] ST_UPD  = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_CMP  = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_OUT  = 4'd7;

   logic [3:0] state_ff;

   // effective lengths
   logic [10:0] s11, l11, m11, w11;
   logic [FW-1:0] s_len, l_len, w_len;
   always_comb begin
      s11 = 11'(cfg.short_len);
      if (s11 == 11'd0) s11 = 11'd1;
      else if (s11 > 11'(MAX_WINDOW - 1)) s11 = 11'(MAX_WINDOW - 1);
      l11 = 11'(cfg.long_len);
      if (l11 == 11'd0) l11 = 11'd1;
      else if (l11 > 11'(MAX_WINDOW - 1)) l11 = 11'(MAX_WINDOW - 1);
      m11 = ((s11 > l11) ? s11 : l11) + 11'd1;
      w11 = (11'(cfg.window_len) > m11) ? 11'(cfg.window_len) : m11;
      if (w11 > 11'(MAX_WINDOW)) w11 = 11'(MAX_WINDOW);
      s_len = FW'(s11);
      l_len = FW'(l11);
      w_len = FW'(w11);
   end

   // per-instrument tracks
   logic [FW-1:0]  fill_ff  [MAX_INSTRUMENTS];
   logic [SLW-1:0] wslot_ff [MAX_INSTRUMENTS];
   logic [SW-1:0]  ssum_ff  [MAX_INSTRUMENTS];
   logic [SW-1:0]  lsum_ff  [MAX_INSTRUMENTS];

   logic [30:0] hist_mem [MAX_INSTRUMENTS * MAX_WINDOW];
   logic [30:0] mem_rd_ff;
   logic [AW-1:0] mem_ra, mem_wa;
   logic mem_we;

   dmac_pkg::bar_type item_ff;
   logic [IW-1:0]  idx_ff;
   logic [FW-1:0]  have_ff;
   logic [SLW-1:0] slot_ff;
   logic [SW-1:0]  s_prev_ff, l_prev_ff, s_now_ff, l_now_ff;
   logic [30:0]    olds_ff;
   logic           buy_ff, sell_ff;
   logic [52:0]    need_ff;
   logic [36:0]    div_ff;
   logic [47:0]    rem_ff;
   logic [6:0]     q_ff;
   logic [2:0]     k_ff;
   logic           res_side_ff;
   logic [31:0]    res_price_ff;
   logic [19:0]    res_vol_ff;

   logic           rsp_valid_ff;
   logic           rsp_side_ff;
   logic [3:0]     rsp_inst_ff;
   logic [31:0]    rsp_price_ff;
   logic [19:0]    rsp_vol_ff;

   logic [AW-1:0] base;
   logic [SLW:0]  old_s_t, old_l_t;
   logic [SLW-1:0] old_s, old_l;
   always_comb begin
      base    = AW'(idx_ff) * AW'(MAX_WINDOW);
      old_s_t = (SLW+1)'(slot_ff) + (SLW+1)'(MAX_WINDOW) - (SLW+1)'(s_len);
      if (old_s_t >= (SLW+1)'(MAX_WINDOW)) old_s_t = old_s_t - (SLW+1)'(MAX_WINDOW);
      old_l_t = (SLW+1)'(slot_ff) + (SLW+1)'(MAX_WINDOW) - (SLW+1)'(l_len);
      if (old_l_t >= (SLW+1)'(MAX_WINDOW)) old_l_t = old_l_t - (SLW+1)'(MAX_WINDOW);
      old_s = SLW'(old_s_t);
      old_l = SLW'(old_l_t);
   end

   always_comb begin
      mem_ra = (state_ff == ST_RDL) ? (base + AW'(old_l)) : (base + AW'(old_s));
      mem_wa = base + AW'(slot_ff);
      mem_we = (state_ff == ST_UPD);
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_wa] <= item_ff.close_price;
      mem_rd_ff <= hist_mem[mem_ra];
   end

   // updated sums
   logic [SW-1:0] s_now, l_now;
   logic [FW-1:0] have_new;
   always_comb begin
      s_now = s_prev_ff + SW'(item_ff.close_price)
            - ((have_ff >= s_len) ? SW'(olds_ff) : SW'(0));
      l_now = l_prev_ff + SW'(item_ff.close_price)
            - ((have_ff >= l_len) ? SW'(mem_rd_ff) : SW'(0));
      have_new = (have_ff < FW'(MAX_WINDOW)) ? have_ff + FW'(1) : have_ff;
   end

   logic [PW-1:0] sn, ln, sp, lp;
   always_comb begin
      sn = PW'(s_now_ff)  * PW'(l_len);
      ln = PW'(l_now_ff)  * PW'(s_len);
      sp = PW'(s_prev_ff) * PW'(l_len);
      lp = PW'(l_prev_ff) * PW'(s_len);
   end

   logic [47:0] div_sh;
   logic        div_ge;
   logic [6:0]  q_next;
   always_comb begin
      div_sh = 48'(div_ff) << k_ff;
      div_ge = rem_ff >= div_sh;
      q_next = q_ff;
      if (div_ge && k_ff != 3'd7) q_next[k_ff] = 1'b1;
   end

   logic [IW-1:0] q_idx;
   assign q_idx = IW'(q_bar.instrument);
   assign pop   = (state_ff == ST_IDLE) && q_not_empty;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_INSTRUMENTS; i++) begin
            fill_ff[i]  <= '0;
            wslot_ff[i] <= '0;
            ssum_ff[i]  <= '0;
            lsum_ff[i]  <= '0;
         end
      end else begin
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (clear_tracks) begin
            for (int i = 0; i < MAX_INSTRUMENTS; i++) begin
               fill_ff[i]  <= '0;
               wslot_ff[i] <= '0;
               ssum_ff[i]  <= '0;
               lsum_ff[i]  <= '0;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  item_ff   <= q_bar;
                  idx_ff    <= q_idx;
                  have_ff   <= fill_ff[q_idx];
                  slot_ff   <= wslot_ff[q_idx];
                  s_prev_ff <= ssum_ff[q_idx];
                  l_prev_ff <= lsum_ff[q_idx];
                  state_ff  <= ST_RDS;
               end
            end
            ST_RDS: state_ff <= ST_RDL;
            ST_RDL: begin
               olds_ff  <= mem_rd_ff;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               s_now_ff <= s_now;
               l_now_ff <= l_now;
               ssum_ff[idx_ff]  <= s_now;
               lsum_ff[idx_ff]  <= l_now;
               fill_ff[idx_ff]  <= have_new;
               wslot_ff[idx_ff] <= (slot_ff == SLW'(MAX_WINDOW - 1)) ? '0 : slot_ff + SLW'(1);
               state_ff <= (have_new >= w_len) ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
               buy_ff   <= (sn >= ln) && (sp < lp);
               sell_ff  <= (ln >= sn) && (lp < sp);
               need_ff  <= 53'(item_ff.position_cost) * 53'(cfg.instrument_count);
               div_ff   <= {36'(item_ff.close_price) * 36'(cfg.instrument_count), 1'b0};
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (buy_ff) begin
                  if (53'(item_ff.total_assets) > need_ff) begin
                     rem_ff   <= item_ff.total_assets - 48'(need_ff);
                     q_ff     <= '0;
                     k_ff     <= 3'd7;
                     state_ff <= ST_DIV;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else if (sell_ff) begin
                  res_side_ff  <= dmac_pkg::SIDE_SELL;
                  res_price_ff <= (32'(item_ff.close_price) >= dmac_pkg::PRICE_OFFSET)
                                  ? 32'(item_ff.close_price) - dmac_pkg::PRICE_OFFSET : 32'd0;
                  res_vol_ff   <= (item_ff.open_volume > item_ff.closed_volume)
                                  ? item_ff.open_volume - item_ff.closed_volume : 20'd0;
                  state_ff     <= ST_OUT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               res_side_ff  <= dmac_pkg::SIDE_BUY;
               res_price_ff <= 32'(item_ff.close_price) + dmac_pkg::PRICE_OFFSET;
               if (k_ff == 3'd7) begin
                  // quotient of 128 or more saturates at the cap
                  if (div_ge) begin
                     res_vol_ff <= dmac_pkg::BUY_CAP;
                     state_ff   <= ST_OUT;
                  end else begin
                     k_ff <= 3'd6;
                  end
               end else begin
                  if (div_ge) rem_ff <= rem_ff - div_sh;
                  q_ff <= q_next;
                  if (k_ff == 3'd0) begin
                     res_vol_ff <= (20'(q_next) > dmac_pkg::BUY_CAP)
                                   ? dmac_pkg::BUY_CAP : 20'(q_next);
                     state_ff   <= ST_OUT;
                  end else begin
                     k_ff <= k_ff - 3'd1;
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_side_ff  <= res_side_ff;
                  rsp_inst_ff  <= item_ff.instrument;
                  rsp_price_ff <= res_price_ff;
                  rsp_vol_ff   <= res_vol_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_side   = rsp_side_ff;
   assign rsp_inst   = rsp_inst_ff;
   assign rsp_price  = rsp_price_ff;
   assign rsp_volume = rsp_vol_ff;
endmodule

@@ hw/rtl/dual_moving_average_crossover.sv @@
// dual moving average crossover: per-instrument short/long mean cross gives buy or sell orders
// per bar: RDS, RDL, UPD, MUL, CMP, then OUT for a sell, or the 8-step divider and OUT for a buy
// the back end takes a new bar from the queue only when idle, so it handles one bar at a time;
// bars that do not yet fill the window return to idle after UPD; the back-end sequencer and its
// single history memory read port set the pace, and a stalled result holds the back end
// reset: synchronous, active high; clears all tracks and loads default lengths, no clearing pass
module dual_moving_average_crossover #(
   parameter int MAX_INSTRUMENTS = 16,
   parameter int MAX_WINDOW      = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // instrument, close_price, total_assets, position_cost, open_volume, closed_volume
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // order_instrument, order_price, order_volume
   output logic [55:0]  rsp_tdata,
   // side
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [7:0]   csr_data
);
   dmac_pkg::cfg_type cfg_ff;
   logic clear_tracks;

   assign csr_ready    = 1'b1;
   assign clear_tracks = csr_valid && (csr_index == 8'(dmac_pkg::REG_SHORT_LEN)
                                    || csr_index == 8'(dmac_pkg::REG_LONG_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_len        <= dmac_pkg::SHORT_LEN_RESET;
         cfg_ff.long_len         <= dmac_pkg::LONG_LEN_RESET;
         cfg_ff.window_len       <= dmac_pkg::WINDOW_LEN_RESET;
         cfg_ff.instrument_count <= dmac_pkg::INST_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            8'(dmac_pkg::REG_SHORT_LEN):  cfg_ff.short_len        <= csr_data[5:0];
            8'(dmac_pkg::REG_LONG_LEN):   cfg_ff.long_len         <= csr_data[5:0];
            8'(dmac_pkg::REG_WINDOW_LEN): cfg_ff.window_len       <= csr_data[6:0];
            8'(dmac_pkg::REG_INST_COUNT): cfg_ff.instrument_count <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   dmac_pkg::bar_type in_bar, push_bar, head_bar;
   logic push, q_full, q_not_empty, pop;

   assign in_bar = dmac_pkg::bar_type'(req_tdata[170:0]);

   dmac_front #(.MAX_INSTRUMENTS(MAX_INSTRUMENTS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_bar(in_bar),
      .inst_count(cfg_ff.instrument_count),
      .push(push), .push_bar(push_bar), .q_full(q_full)
   );

   dmac_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_bar(push_bar), .full(q_full),
      .pop(pop), .not_empty(q_not_empty), .head_bar(head_bar)
   );

   logic        o_side;
   logic [3:0]  o_inst;
   logic [31:0] o_price;
   logic [19:0] o_vol;

   dmac_back #(.MAX_INSTRUMENTS(MAX_INSTRUMENTS), .MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .clear_tracks(clear_tracks),
      .q_not_empty(q_not_empty), .q_bar(head_bar), .pop(pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_side(o_side), .rsp_inst(o_inst), .rsp_price(o_price), .rsp_volume(o_vol)
   );

   assign rsp_tdata = {o_vol, o_price, o_inst};
   assign rsp_tuser = o_side;
endmodule
